FILE: src/ipv6p_pkg.sv
package ipv6p_pkg;

  localparam int unsigned NumGroups = 8;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned CurW      = 17;
  localparam int unsigned CountW    = 4;
  localparam int unsigned AccW      = CurW + 4;

  localparam logic [CurW-1:0]   GroupLimit = 17'h10000;
  localparam logic [CountW-1:0] CountMax   = 4'd15;

  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindDigit = 2'd1,
    KindColon = 2'd2,
    KindLead  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrBadChar    = 3'd1,
    ErrGroupBig   = 3'd2,
    ErrCount      = 3'd3,
    ErrDoubleComp = 3'd4,
    ErrEdgeColon  = 3'd5
  } err_e;

  typedef struct packed {
    logic       is_hex;
    logic       is_colon;
    logic [3:0] digit;
  } char_t;

  // Everything the packing step needs once the final character is in.
  typedef struct packed {
    logic [NumGroups-1:0][GroupW-1:0] head;
    logic [NumGroups-1:0][GroupW-1:0] tail;
    logic [CountW-1:0]                split;
    logic [CountW-1:0]                total;
    logic                             compress;
    err_e                             code;
  } fin_t;

  typedef struct packed {
    logic [2*64-1:0] addr;
    logic            ok;
    err_e            code;
  } res_t;

  // Lower rank wins when two errors are found in the same text.
  function automatic logic [2:0] err_rank(err_e code);
    logic [2:0] r;
    case (code)
      ErrBadChar:    r = 3'd0;
      ErrCount:      r = 3'd1;
      ErrDoubleComp: r = 3'd2;
      ErrEdgeColon:  r = 3'd3;
      ErrGroupBig:   r = 3'd4;
      default:       r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic err_e err_merge(err_e held, err_e found);
    return (err_rank(found) < err_rank(held)) ? found : held;
  endfunction

endpackage

FILE: src/ipv6p_char_class.sv
module ipv6p_char_class (
  input  logic [7:0]            ch_i,
  output ipv6p_pkg::char_t      cls_o
);
  import ipv6p_pkg::*;

  always_comb begin
    cls_o          = '0;
    cls_o.is_colon = (ch_i == 8'h3A);
    if (ch_i inside {[8'h30:8'h39]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.digit  = ch_i[3:0];
    end else if (ch_i inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // Letters a to f in either case: low three bits run 1 to 6.
      cls_o.is_hex = 1'b1;
      cls_o.digit  = 4'(ch_i[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

FILE: src/ipv6p_scan.sv
module ipv6p_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             last_i,
  input  ipv6p_pkg::char_t cls_i,
  output ipv6p_pkg::fin_t  fin_o
);
  import ipv6p_pkg::*;

  logic [NumGroups-1:0][GroupW-1:0] head_q, head_d;
  logic [NumGroups-1:0][GroupW-1:0] tail_q, tail_d;
  logic [CurW-1:0]   cur_q, cur_d, cur_upd, close_val;
  logic [AccW-1:0]   cur_acc;
  logic [CountW-1:0] before_q, before_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] colon_q, colon_d;
  logic              compress_q, compress_d;
  logic              lead_q, lead_d;
  kind_e             kind_q, kind_d;
  err_e              err_q, err_d, code;
  logic              close;

  assign cur_acc = {cur_q, 4'b0000} + AccW'(cls_i.digit);
  assign cur_upd = (cur_acc > AccW'(GroupLimit)) ? GroupLimit : cur_acc[CurW-1:0];

  always_comb begin
    cur_d      = cur_q;
    before_d   = before_q;
    total_d    = total_q;
    colon_d    = colon_q;
    compress_d = compress_q;
    lead_d     = lead_q;
    kind_d     = kind_q;
    err_d      = err_q;
    close      = 1'b0;
    close_val  = cur_q;

    if (cls_i.is_hex) begin
      if (kind_q == KindLead) begin
        err_d = err_merge(err_d, ErrEdgeColon);
      end
      cur_d  = cur_upd;
      kind_d = KindDigit;
    end else if (cls_i.is_colon) begin
      if (colon_q != CountMax) begin
        colon_d = colon_q + 4'd1;
      end
      if (kind_q == KindDigit) begin
        close = 1'b1;
      end
      if (kind_q == KindColon || kind_q == KindLead) begin
        if (compress_q) begin
          err_d = err_merge(err_d, ErrDoubleComp);
        end else begin
          compress_d = 1'b1;
          before_d   = total_q;
        end
        kind_d = KindColon;
      end else if (kind_q == KindStart) begin
        lead_d = 1'b1;
        kind_d = KindLead;
      end else begin
        kind_d = KindColon;
      end
    end else begin
      err_d = err_merge(err_d, ErrBadChar);
    end

    if (last_i && kind_d == KindDigit) begin
      close     = 1'b1;
      close_val = cur_d;
    end

    if (close) begin
      if (close_val[CurW-1]) begin
        err_d = err_merge(err_d, ErrGroupBig);
      end
      if (total_q != CountMax) begin
        total_d = total_q + 4'd1;
      end
      cur_d = '0;
    end
  end

  // Groups before the compressed run sit at their own index; groups after it
  // enter a shift line from the top so that they end up right-aligned.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (close && !compress_q && !total_q[CountW-1]) begin
      head_d[total_q[2:0]] = close_val[GroupW-1:0];
    end
    if (close && compress_q) begin
      for (int i = 0; i < NumGroups - 1; i++) begin
        tail_d[i] = tail_q[i+1];
      end
      tail_d[NumGroups-1] = close_val[GroupW-1:0];
    end
  end

  always_comb begin
    code = err_d;
    if (cls_i.is_colon && kind_q != KindColon && kind_q != KindLead) begin
      code = err_merge(code, ErrEdgeColon);
    end
    if (colon_d < 4'd2 || colon_d > 4'd8 ||
        (colon_d == 4'd8 && !lead_d && !cls_i.is_colon)) begin
      code = err_merge(code, ErrCount);
    end
    if (code == ErrNone) begin
      if (compress_d ? (total_d > 4'd7) : (total_d != 4'd8)) begin
        code = ErrCount;
      end
    end
    fin_o.head     = head_d;
    fin_o.tail     = tail_d;
    fin_o.split    = before_d;
    fin_o.total    = total_d;
    fin_o.compress = compress_d;
    fin_o.code     = code;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      before_q   <= '0;
      total_q    <= '0;
      colon_q    <= '0;
      compress_q <= 1'b0;
      lead_q     <= 1'b0;
      kind_q     <= KindStart;
      err_q      <= ErrNone;
    end else if (accept_i) begin
      if (last_i) begin
        cur_q      <= '0;
        before_q   <= '0;
        total_q    <= '0;
        colon_q    <= '0;
        compress_q <= 1'b0;
        lead_q     <= 1'b0;
        kind_q     <= KindStart;
        err_q      <= ErrNone;
      end else begin
        cur_q      <= cur_d;
        before_q   <= before_d;
        total_q    <= total_d;
        colon_q    <= colon_d;
        compress_q <= compress_d;
        lead_q     <= lead_d;
        kind_q     <= kind_d;
        err_q      <= err_d;
      end
    end
  end

endmodule

FILE: src/ipv6p_pack.sv
module ipv6p_pack (
  input  ipv6p_pkg::fin_t fin_i,
  output ipv6p_pkg::res_t res_o
);
  import ipv6p_pkg::*;

  logic [NumGroups-1:0][GroupW-1:0] grp;

  always_comb begin
    for (int i = 0; i < NumGroups; i++) begin
      grp[i] = '0;
      if (fin_i.code == ErrNone) begin
        if (!fin_i.compress || CountW'(i) < fin_i.split) begin
          grp[i] = fin_i.head[i];
        end else if (5'(i) + {1'b0, fin_i.total} >=
                     5'(NumGroups) + {1'b0, fin_i.split}) begin
          grp[i] = fin_i.tail[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumGroups; i++) begin
      res_o.addr[(NumGroups-1-i)*GroupW +: GroupW] = grp[i];
    end
    res_o.ok   = (fin_i.code == ErrNone);
    res_o.code = fin_i.code;
  end

endmodule

FILE: src/ipv6_text_to_binary_parser.sv
// IPv6 text parser: the address text enters one character per beat on the
// input channel, with last_i marking its final character, and leaves as one
// result beat carrying the 128-bit address (group 0 in the top bits of
// addr_high_o), ok_o and err_code_o. A character is taken in every cycle
// unless the input stalls as told below; the result appears in the output
// register on the cycle after the final character is accepted, and texts
// may follow each other without a gap. The only thing that slows the input
// is the output register: while a result waits there and out_ready_i is low,
// in_ready_o is low as well. On an error the address is all zeros and ok_o
// is low. After each final character the parser clears itself for the next
// text, so no flush is needed between texts.
module ipv6_text_to_binary_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o,
  output logic        ok_o,
  output logic [2:0]  err_code_o
);
  import ipv6p_pkg::*;

  char_t cls;
  fin_t  fin;
  res_t  res;
  logic  accept;

  logic              out_valid_q, out_valid_d;
  logic [2*64-1:0]   addr_q;
  logic              ok_q;
  err_e              code_q;

  // The input side only stalls when the result register is full and the
  // downstream side is not taking it this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Character decode: hex digit value or colon.
  ipv6p_char_class u_char_class (
    .ch_i  (ch_i),
    .cls_o (cls)
  );

  // Per-character state: group being built, stored groups, colon and
  // compression bookkeeping, and the best-ranked error so far.
  ipv6p_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .last_i   (last_i),
    .cls_i    (cls),
    .fin_o    (fin)
  );

  // Places the stored groups around the zero run and applies the status.
  ipv6p_pack u_pack (
    .fin_i (fin),
    .res_o (res)
  );

  assign out_valid_d = (accept && last_i) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload is loaded only with the final character of a text.
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      addr_q <= res.addr;
      ok_q   <= res.ok;
      code_q <= res.code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign addr_high_o = addr_q[127:64];
  assign addr_low_o  = addr_q[63:0];
  assign ok_o        = ok_q;
  assign err_code_o  = code_q;

endmodule

FILE: src/ipv6p_checker.sv
module ipv6p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] addr_high_o,
  input logic [63:0] addr_low_o,
  input logic        ok_o,
  input logic [2:0]  err_code_o
);
  import ipv6p_pkg::*;

  // A result beat that is not taken holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(addr_high_o) && $stable(addr_low_o) &&
      $stable(ok_o) && $stable(err_code_o))
    else $error("result beat changed while stalled");

  // The status flag and the error code agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ok_o == (err_code_o == ErrNone)))
    else $error("ok and error code disagree");

  // A failed parse gives an all-zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (addr_high_o == 64'd0) && (addr_low_o == 64'd0))
    else $error("address not zero on error");

  // The final character of a text yields a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> out_valid_o)
    else $error("no result after final character");

  // With no result waiting, the parser always takes a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind ipv6_text_to_binary_parser ipv6p_checker u_ipv6p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .addr_high_o (addr_high_o),
  .addr_low_o  (addr_low_o),
  .ok_o        (ok_o),
  .err_code_o  (err_code_o)
);
